FILE: design/gsfi_pkg.sv
// ----------------------------------------------------------------------------
// gsfi_pkg: shared types and constants for the gyro frame sync integrator
// Result kinds, error codes, field widths and the front-to-back entry type.
// ----------------------------------------------------------------------------
package gsfi_pkg;

  localparam int SLOTS       = 6;
  localparam int RUN_BITS_DEF = 8;

  localparam logic [7:0]  DECIMATION_RST  = 8'd10;
  localparam logic [15:0] PERIOD_RST      = 16'd1000;
  localparam logic [7:0]  MIN_RUN_RST     = 8'd20;
  localparam logic [7:0]  MAX_RIVAL_RST   = 8'd3;

  typedef enum logic [2:0] {
    KIND_LOCK_GAINED = 3'd0,
    KIND_LOCK_LOST   = 3'd1,
    KIND_INVALID     = 3'd2,
    KIND_SAMPLE      = 3'd3,
    KIND_REPORT      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LOST    = 2'd1,
    ERR_INVALID = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_DECIMATION = 2'd0,
    REG_PERIOD     = 2'd1,
    REG_MIN_RUN    = 2'd2,
    REG_MAX_RIVAL  = 2'd3
  } reg_idx_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic              lost;     // lock dropped by this byte
    logic              gained;   // lock gained by this byte
    logic              frame;    // frame completes on this byte
    logic              bad;      // frame validity bit clear
    logic [2:0]        slot;     // locked slot (or slot just lost)
    logic signed [21:0] sample;
  } item_t;

endpackage

FILE: design/gyro_serial_frame_sync_integrator.sv
// ----------------------------------------------------------------------------
// gyro_serial_frame_sync_integrator: gyro byte stream frame sync and integrator
// Locks onto 6-byte frames and integrates the rate samples.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue is not full. The front
// end updates slot run counts, the lock and frame detection in the cycle
// the byte is accepted, a two-entry queue decouples it from the back end,
// which emits one result per cycle while out_stall is low; a byte that
// both gains lock and completes a frame yields two results, which are
// registered. Configuration writes are always ready and are registered.
module gyro_serial_frame_sync_integrator
  import gsfi_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [2:0]         lock_slot,
  output logic signed [21:0] rate_sample,
  output logic signed [63:0] total_integral,
  output logic signed [45:0] window_sum,
  output logic [23:0]        window_time,
  output logic [1:0]         last_error,
  output logic               last
);

  logic [7:0]  decimation, lock_min_run, lock_max_rival;
  logic [15:0] sample_period_us;
  item_t       f_item, q_item;
  logic        q_full, q_empty, q_pop, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= DECIMATION_RST;
      sample_period_us <= PERIOD_RST;
      lock_min_run <= MIN_RUN_RST;
      lock_max_rival <= MAX_RIVAL_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DECIMATION: decimation <= cfg_data[7:0];
        REG_PERIOD:     sample_period_us <= cfg_data;
        REG_MIN_RUN:    lock_min_run <= cfg_data[7:0];
        REG_MAX_RIVAL:  lock_max_rival <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gsfi_front #(.RUN_BITS(RUN_BITS)) u_front (
    .clk, .rst, .take, .rx_byte, .lock_min_run, .lock_max_rival, .item(f_item)
  );

  gsfi_queue u_queue (
    .clk, .rst, .push(take && (f_item.lost || f_item.gained || f_item.frame)),
    .din(f_item), .full(q_full), .pop(q_pop), .empty(q_empty), .dout(q_item)
  );

  gsfi_back u_back (
    .clk, .rst, .q_empty, .q_item, .q_pop, .decimation, .sample_period_us,
    .valid(out_valid), .stall(out_stall), .kind, .lock_slot, .rate_sample,
    .total_integral, .window_sum, .window_time, .last_error, .last
  );

endmodule

FILE: design/gsfi_front.sv
// ----------------------------------------------------------------------------
// gsfi_front: slot tracking, run counts and lock decision
// Classifies each byte into lock events and completed frames.
// ----------------------------------------------------------------------------
module gsfi_front
  import gsfi_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic [7:0] lock_min_run,
  input  logic [7:0] lock_max_rival,
  output item_t      item
);

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  logic [2:0]          byte_slot;
  logic                lock_valid;
  logic [2:0]          locked_slot;
  logic [1:0]          prev_counter [SLOTS];
  logic [RUN_BITS-1:0] good_run     [SLOTS];
  logic [7:0]          frame_store  [SLOTS];

  logic [RUN_BITS-1:0] run_new [SLOTS];
  logic [7:0]          fs_new  [SLOTS];
  logic                good_step, lost, gained, lock_after, frame;
  logic [2:0]          best, rival, next_slot, slot_after;
  logic [21:0]         raw;

  assign good_step = (rx_byte[7:6] == prev_counter[byte_slot] + 2'd1);
  assign lost      = !good_step && lock_valid && (byte_slot == locked_slot);
  assign next_slot = (byte_slot == 3'(SLOTS - 1)) ? 3'd0 : byte_slot + 3'd1;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      fs_new[i]  = (3'(i) == byte_slot) ? rx_byte : frame_store[i];
      run_new[i] = good_run[i];
      if (3'(i) == byte_slot) begin
        if (!good_step) run_new[i] = '0;
        else if (good_run[i] != RUN_MAX) run_new[i] = good_run[i] + 1'b1;
      end
      if (lost) run_new[i] = '0;
    end
  end

  // Lowest-numbered maximum, then the largest among the rest.
  always_comb begin
    best = 3'd0;
    for (int i = 1; i < SLOTS; i++)
      if (run_new[i] > run_new[best]) best = 3'(i);
    rival = (best == 3'(SLOTS - 1)) ? 3'd0 : best + 3'd1;
    for (int i = 0; i < SLOTS; i++)
      if (3'(i) != best && run_new[i] > run_new[rival]) rival = 3'(i);
  end

  assign gained = !lock_valid && !lost && byte_slot == 3'd0 &&
                  {{(16-RUN_BITS){1'b0}}, run_new[best]} > {8'd0, lock_min_run} &&
                  {{(16-RUN_BITS){1'b0}}, run_new[rival]} < {8'd0, lock_max_rival};
  assign lock_after = gained || (lock_valid && !lost);
  assign slot_after = gained ? best : locked_slot;
  assign frame      = lock_after && (next_slot == slot_after);

  // Frame begins at next_slot: d0 = fs[next], d3..d5 follow.
  function automatic logic [2:0] wrap(input logic [2:0] s, input logic [2:0] k);
    logic [3:0] t;
    t = {1'b0, s} + {1'b0, k};
    return (t >= 4'(SLOTS)) ? 3'(t - 4'(SLOTS)) : t[2:0];
  endfunction

  assign raw = {fs_new[wrap(next_slot, 3'd3)][5:0], fs_new[wrap(next_slot, 3'd4)],
                fs_new[wrap(next_slot, 3'd5)]};

  always_comb begin
    item.lost   = lost;
    item.gained = gained;
    item.frame  = frame;
    item.bad    = !fs_new[next_slot][4];
    item.slot   = slot_after;
    item.sample = raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_slot   <= 3'd0;
      lock_valid  <= 1'b0;
      locked_slot <= 3'd0;
      for (int i = 0; i < SLOTS; i++) begin
        prev_counter[i] <= 2'd0;
        good_run[i]     <= '0;
        frame_store[i]  <= 8'd0;
      end
    end else if (take) begin
      byte_slot   <= next_slot;
      lock_valid  <= lock_after;
      locked_slot <= slot_after;
      prev_counter[byte_slot] <= rx_byte[7:6];
      for (int i = 0; i < SLOTS; i++) begin
        good_run[i]    <= run_new[i];
        frame_store[i] <= fs_new[i];
      end
    end
  end

  property p_lock_needs_slot0;
    @(posedge clk) disable iff (rst) (take && gained) |-> byte_slot == 3'd0;
  endproperty
  a_lock_needs_slot0: assert property (p_lock_needs_slot0) else $error("lock off slot 0");

  property p_no_lost_unlocked;
    @(posedge clk) disable iff (rst) lost |-> lock_valid;
  endproperty
  a_no_lost_unlocked: assert property (p_no_lost_unlocked) else $error("lost while unlocked");

  property p_slot_range;
    @(posedge clk) disable iff (rst) byte_slot < 3'(SLOTS) && locked_slot < 3'(SLOTS);
  endproperty
  a_slot_range: assert property (p_slot_range) else $error("slot out of range");

endmodule

FILE: design/gsfi_queue.sv
// ----------------------------------------------------------------------------
// gsfi_queue: short queue between front and back
// Two-entry FIFO of classified bytes.
// ----------------------------------------------------------------------------
module gsfi_queue
  import gsfi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t dout
);

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) !(push && full);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk) disable iff (rst) !(pop && empty);
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count_range;
    @(posedge clk) disable iff (rst) count != 2'd3;
  endproperty
  a_count_range: assert property (p_count_range) else $error("bad count");

endmodule

FILE: design/gsfi_back.sv
// ----------------------------------------------------------------------------
// gsfi_back: integration and result emission
// Accumulates sample times period and emits one or two results per item.
// ----------------------------------------------------------------------------
module gsfi_back
  import gsfi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic [7:0]         decimation,
  input  logic [15:0]        sample_period_us,
  output logic               valid,
  input  logic               stall,
  output logic [2:0]         kind,
  output logic [2:0]         lock_slot,
  output logic signed [21:0] rate_sample,
  output logic signed [63:0] total_integral,
  output logic signed [45:0] window_sum,
  output logic [23:0]        window_time,
  output logic [1:0]         last_error,
  output logic               last
);

  logic signed [63:0] integral_acc;
  logic signed [47:0] window_acc;
  logic [23:0]        window_time_acc;
  logic [7:0]         window_count;
  logic [1:0]         error_code;
  logic               first_done;   // lock event of a two-result item sent

  logic               has_event, has_frame, two, emit_event, load;
  logic signed [38:0] prod;
  logic signed [63:0] int_new;
  logic signed [47:0] win_new;
  logic [23:0]        wt_new;
  logic [7:0]         wc_new;
  logic               report;

  assign has_event  = q_item.lost || q_item.gained;
  assign has_frame  = q_item.frame;
  assign two        = has_event && has_frame;
  assign emit_event = has_event && !first_done;
  assign load       = !q_empty && (!valid || !stall);
  assign q_pop      = load && !(two && !first_done);

  assign prod    = q_item.sample * $signed({1'b0, sample_period_us});
  assign int_new = integral_acc + 64'(prod);
  assign win_new = window_acc + 48'(prod);
  assign wt_new  = window_time_acc + {8'd0, sample_period_us};
  assign wc_new  = window_count + 8'd1;
  assign report  = wc_new == decimation;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      first_done <= 1'b0;
      integral_acc <= '0;
      window_acc <= '0;
      window_time_acc <= '0;
      window_count <= '0;
      error_code <= ERR_NONE;
    end else begin
      if (valid && !stall) valid <= 1'b0;
      if (load) begin
        valid <= 1'b1;
        first_done <= two && !first_done;
        lock_slot <= q_item.slot;
        rate_sample <= '0;
        window_sum <= '0;
        window_time <= '0;
        last <= !(two && !first_done);
        if (emit_event) begin
          kind <= q_item.lost ? KIND_LOCK_LOST : KIND_LOCK_GAINED;
          if (q_item.lost) error_code <= ERR_LOST;
          last_error <= q_item.lost ? ERR_LOST : error_code;
          total_integral <= integral_acc;
        end else if (q_item.bad) begin
          kind <= KIND_INVALID;
          error_code <= ERR_INVALID;
          last_error <= ERR_INVALID;
          total_integral <= integral_acc;
        end else begin
          rate_sample <= q_item.sample;
          integral_acc <= int_new;
          total_integral <= int_new;
          last_error <= error_code;
          if (report) begin
            kind <= KIND_REPORT;
            window_sum <= win_new[45:0];
            window_time <= wt_new;
            window_acc <= '0;
            window_time_acc <= '0;
            window_count <= '0;
          end else begin
            kind <= KIND_SAMPLE;
            window_acc <= win_new;
            window_time_acc <= wt_new;
            window_count <= wc_new;
          end
        end
      end
    end
  end

  property p_pop_needs_load;
    @(posedge clk) disable iff (rst) q_pop |-> load;
  endproperty
  a_pop_needs_load: assert property (p_pop_needs_load) else $error("pop without load");

  property p_first_not_last;
    @(posedge clk) disable iff (rst) (load && two && !first_done) |=> first_done;
  endproperty
  a_first_not_last: assert property (p_first_not_last) else $error("split lost");

  property p_window_clear;
    @(posedge clk) disable iff (rst)
      (valid && kind == KIND_REPORT && $rose(valid)) |-> window_count == 8'd0;
  endproperty
  a_window_clear: assert property (p_window_clear) else $error("window not cleared");

endmodule
